// ----- rtl/core/dsps_pkg.sv -----
// Shared types and constants for the dust sensor pulse sampler.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package dsps_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int TICK_W       = 16;
  localparam int DENS_W       = 13;
  localparam int GAIN_W       = 13;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  localparam longint unsigned DENSITY_GAIN   = 64'd5610;
  localparam logic [DENS_W-1:0] DENSITY_OFFSET = 13'd1000;
  localparam logic [DENS_W-1:0] DENSITY_MAX    = 13'd4610;

  localparam logic [TICK_W-1:0] SAMPLE_DELAY_RST = 16'd280;
  localparam logic [TICK_W-1:0] HOLD_RST         = 16'd40;
  localparam logic [TICK_W-1:0] SLEEP_RST        = 16'd9680;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_SAMPLE_DELAY = 2'd0;
  localparam logic [1:0] REG_HOLD         = 2'd1;
  localparam logic [1:0] REG_SLEEP        = 2'd2;

  // phase codes as seen on the phase port
  localparam logic [1:0] PH_CODE_IDLE   = 2'd0;
  localparam logic [1:0] PH_CODE_SAMPLE = 2'd1;
  localparam logic [1:0] PH_CODE_WAIT   = 2'd2;
  localparam logic [1:0] PH_CODE_SLEEP  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SAMPLE = 4'b0010,
    PH_WAIT   = 4'b0100,
    PH_SLEEP  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              led_drive;
    logic [1:0]        phase;
    logic [DENS_W-1:0] density_tenths;
    logic              density_updated;
  } res_t;

  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_IDLE:   code = PH_CODE_IDLE;
      PH_SAMPLE: code = PH_CODE_SAMPLE;
      PH_WAIT:   code = PH_CODE_WAIT;
      PH_SLEEP:  code = PH_CODE_SLEEP;
      default:   code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/dust_sensor_pulse_sampler.sv -----
// Pulsed-LED dust sensor sequencer and density readout, with APB config.
// Depends on dsps_pkg.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   in       | in_valid / in_ready       | adc_sample
//   out      | out_valid / out_ready     | led_drive, phase, density_tenths,
//            |                           | density_updated
//   cfg      | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// One tick word per cycle unless a stalled output fills the skid entry; each result word is registered.
// An output register plus one skid entry; in_ready drops once both hold a word.
// The density quotient is prepared in two stages after capture, ahead of the
// first sleeping tick, so the tick path holds only a subtract and compare.
// rst is synchronous: phase idle, timer and density cleared, registers to defaults.
`timescale 1ns / 1ps

module dust_sensor_pulse_sampler
  import dsps_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] adc_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                led_drive,
  output logic [1:0]          phase,
  output logic [DENS_W-1:0]   density_tenths,
  output logic                density_updated,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int P_W = ADC_BITS + GAIN_W;
  localparam int R_W = P_W + 1;
  localparam longint unsigned FULL_SCALE = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned RECIP_L    = (DENSITY_GAIN * (64'd1 << ADC_BITS)) / FULL_SCALE;
  localparam logic [GAIN_W-1:0] RECIP    = RECIP_L[GAIN_W-1:0];
  localparam logic [GAIN_W-1:0] GAIN     = DENSITY_GAIN[GAIN_W-1:0];
  localparam logic [R_W-1:0]    FS_R     = FULL_SCALE[R_W-1:0];

  // config
  logic [TICK_W-1:0] sample_delay_ticks;
  logic [TICK_W-1:0] hold_ticks;
  logic [TICK_W-1:0] sleep_ticks;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_delay_ticks <= SAMPLE_DELAY_RST;
      hold_ticks         <= HOLD_RST;
      sleep_ticks        <= SLEEP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SAMPLE_DELAY: sample_delay_ticks <= pwdata[TICK_W-1:0];
        REG_HOLD:         hold_ticks         <= pwdata[TICK_W-1:0];
        REG_SLEEP:        sleep_ticks        <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SAMPLE_DELAY: prdata = {{(APB_DW-TICK_W){1'b0}}, sample_delay_ticks};
      REG_HOLD:         prdata = {{(APB_DW-TICK_W){1'b0}}, hold_ticks};
      REG_SLEEP:        prdata = {{(APB_DW-TICK_W){1'b0}}, sleep_ticks};
      default:          prdata = '0;
    endcase
  end

  // handshake
  logic in_fire;
  logic out_load;
  logic skid_valid;
  res_t out_word;
  res_t skid_word;
  res_t res_next;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_load = !out_valid || out_ready;

  // sequencer state
  phase_t            phase_reg, phase_reg_next;
  logic [TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [DENS_W-1:0] density_reg, density_reg_next;
  logic              led_on, led_on_next;
  logic              capture;
  logic              updated;
  logic [TICK_W-1:0] elapsed_inc;

  // density pipeline: product and estimate at capture, corrected quotient next
  logic [P_W-1:0]    prod_reg;
  logic [GAIN_W-1:0] est_reg;
  logic [DENS_W-1:0] quot_reg;
  logic [P_W-1:0]    est_full;
  logic [R_W-1:0]    rem;
  logic [DENS_W-1:0] quot_next;

  assign elapsed_inc = (elapsed_ticks == {TICK_W{1'b1}}) ? elapsed_ticks
                                                         : elapsed_ticks + 1'b1;

  always_comb begin
    phase_reg_next     = phase_reg;
    elapsed_ticks_next = elapsed_ticks;
    density_reg_next   = density_reg;
    led_on_next        = led_on;
    capture            = 1'b0;
    updated            = 1'b0;
    case (phase_reg)
      PH_IDLE: begin
        led_on_next        = 1'b1;
        elapsed_ticks_next = '0;
        phase_reg_next     = PH_SAMPLE;
      end
      PH_SAMPLE: begin
        if (elapsed_inc >= sample_delay_ticks) begin
          capture            = 1'b1;
          elapsed_ticks_next = '0;
          phase_reg_next     = PH_WAIT;
        end else begin
          elapsed_ticks_next = elapsed_inc;
        end
      end
      PH_WAIT: begin
        if (elapsed_inc >= hold_ticks) begin
          led_on_next        = 1'b0;
          elapsed_ticks_next = '0;
          phase_reg_next     = PH_SLEEP;
        end else begin
          elapsed_ticks_next = elapsed_inc;
        end
      end
      PH_SLEEP: begin
        elapsed_ticks_next = elapsed_inc;
        if (elapsed_inc >= sleep_ticks) begin
          phase_reg_next = PH_IDLE;
        end
        density_reg_next = (quot_reg > DENSITY_OFFSET) ? quot_reg - DENSITY_OFFSET : '0;
        updated          = 1'b1;
      end
      default: begin
        phase_reg_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res_next.led_drive       = led_on_next;
    res_next.phase           = phase_code(phase_reg_next);
    res_next.density_tenths  = density_reg_next;
    res_next.density_updated = updated;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      elapsed_ticks <= '0;
      density_reg   <= '0;
      led_on        <= 1'b0;
    end else if (in_fire) begin
      phase_reg     <= phase_reg_next;
      elapsed_ticks <= elapsed_ticks_next;
      density_reg   <= density_reg_next;
      led_on        <= led_on_next;
    end
  end

  // estimate = floor(s*RECIP / 2^ADC_BITS) is the quotient or one below it
  assign est_full  = P_W'(adc_sample) * P_W'(RECIP);
  assign rem       = R_W'(prod_reg) + R_W'(est_reg) - (R_W'(est_reg) << ADC_BITS);
  assign quot_next = (rem >= FS_R) ? DENS_W'(est_reg) + 1'b1 : DENS_W'(est_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_reg <= '0;
      est_reg  <= '0;
      quot_reg <= '0;
    end else begin
      if (in_fire && capture) begin
        prod_reg <= P_W'(adc_sample) * P_W'(GAIN);
        est_reg  <= est_full[ADC_BITS +: GAIN_W];
      end
      quot_reg <= quot_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_fire;
      end else begin
        out_valid  <= in_fire;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        out_word <= skid_word;
        if (in_fire) begin
          skid_word <= res_next;
        end
      end else if (in_fire) begin
        out_word <= res_next;
      end
    end else if (in_fire) begin
      skid_word <= res_next;
    end
  end

  assign led_drive       = out_word.led_drive;
  assign phase           = out_word.phase;
  assign density_tenths  = out_word.density_tenths;
  assign density_updated = out_word.density_updated;

endmodule

// ----- rtl/core/dsps_checker.sv -----
// Port-level checks for dust_sensor_pulse_sampler, attached by bind.
// Depends on dsps_pkg.
`timescale 1ns / 1ps

module dsps_checker
  import dsps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              led_drive,
  input logic [1:0]        phase,
  input logic [DENS_W-1:0] density_tenths,
  input logic              density_updated
);

  // LED is lit exactly while sampling or waiting
  a_led_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (led_drive == ((phase == PH_CODE_SAMPLE) || (phase == PH_CODE_WAIT))))
    else $error("led_drive does not match phase");

  // density only recomputed on a sleeping tick (which may end in idle)
  a_update_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && density_updated) |-> ((phase == PH_CODE_SLEEP) || (phase == PH_CODE_IDLE)))
    else $error("density update outside sleep");

  a_density_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (density_tenths <= DENSITY_MAX))
    else $error("density out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(led_drive) && $stable(phase)
                                   && $stable(density_tenths) && $stable(density_updated)))
    else $error("stalled result word changed");

endmodule

bind dust_sensor_pulse_sampler dsps_checker u_dsps_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .led_drive       (led_drive),
  .phase           (phase),
  .density_tenths  (density_tenths),
  .density_updated (density_updated)
);

// ----- tb/tb_dust_sensor_pulse_sampler.sv -----
// Self-checking testbench for dust_sensor_pulse_sampler: tick words in, one result word out per tick.
// Depends on dsps_pkg and the dust_sensor_pulse_sampler RTL; checks every result
// word against an in-bench sequencer and density predictor.
`timescale 1ns / 1ps

module tb_dust_sensor_pulse_sampler;
  import dsps_pkg::*;

  localparam int ADC_W = ADC_BITS_DEF;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [TICK_W-1:0] DEF_DELAY = 16'd280;
  localparam logic [TICK_W-1:0] DEF_HOLD  = 16'd40;
  localparam logic [TICK_W-1:0] DEF_SLEEP = 16'd9680;
  localparam logic [TICK_W-1:0] TICK_MAX  = 16'hFFFF;
  localparam longint unsigned ADC_FULL = (64'd1 << ADC_W) - 64'd1;
  localparam longint unsigned DUST_GAIN = 64'd5610;
  localparam longint unsigned DUST_OFFSET = 64'd1000;
  localparam logic [ADC_W-1:0] ZERO_KNEE = 12'd730;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ADC_W-1:0]    adc_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                led_drive;
  logic [1:0]          phase;
  logic [DENS_W-1:0]   density_tenths;
  logic                density_updated;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  dust_sensor_pulse_sampler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_drive(led_drive), .phase(phase), .density_tenths(density_tenths),
    .density_updated(density_updated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // sequencer model state and timing limits
  logic [1:0]        seq_phase;
  logic [TICK_W-1:0] seq_ticks;
  logic [ADC_W-1:0]  held_sample;
  logic [DENS_W-1:0] density_now;
  logic              led_lit;
  logic [TICK_W-1:0] lim_delay, lim_hold, lim_sleep;

  res_t pending_results[$];
  res_t want, next_word;
  int   words_sent = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_left = 0;

  function automatic logic [DENS_W-1:0] density_of(input logic [ADC_W-1:0] s);
    longint unsigned q;
    q = (longint'(s) * DUST_GAIN) / ADC_FULL;
    if (q <= DUST_OFFSET) return '0;
    return DENS_W'(q - DUST_OFFSET);
  endfunction

  task automatic sequence_tick(input logic [ADC_W-1:0] s, output res_t r);
    logic [TICK_W-1:0] nxt;
    logic              upd;
    upd = 1'b0;
    nxt = (seq_ticks == TICK_MAX) ? seq_ticks : seq_ticks + 16'd1;
    case (seq_phase)
      PH_CODE_IDLE: begin
        led_lit = 1'b1;
        seq_ticks = '0;
        seq_phase = PH_CODE_SAMPLE;
      end
      PH_CODE_SAMPLE: begin
        if (nxt >= lim_delay) begin
          held_sample = s;
          seq_ticks = '0;
          seq_phase = PH_CODE_WAIT;
        end else begin
          seq_ticks = nxt;
        end
      end
      PH_CODE_WAIT: begin
        if (nxt >= lim_hold) begin
          led_lit = 1'b0;
          seq_ticks = '0;
          seq_phase = PH_CODE_SLEEP;
        end else begin
          seq_ticks = nxt;
        end
      end
      default: begin
        seq_ticks = nxt;
        if (nxt >= lim_sleep) seq_phase = PH_CODE_IDLE;
        density_now = density_of(held_sample);
        upd = 1'b1;
      end
    endcase
    r.led_drive = led_lit;
    r.phase = seq_phase;
    r.density_tenths = density_now;
    r.density_updated = upd;
  endtask

  task automatic report(input string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // result check first, then prediction for the word accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report($sformatf("result word %0d with none expected", results_seen));
        end else begin
          want = pending_results.pop_front();
          if (led_drive !== want.led_drive)
            report($sformatf("word %0d led_drive: expected %0d, got %0d",
                             results_seen, want.led_drive, led_drive));
          if (phase !== want.phase)
            report($sformatf("word %0d phase: expected %0d, got %0d",
                             results_seen, want.phase, phase));
          if (density_tenths !== want.density_tenths)
            report($sformatf("word %0d density_tenths: expected %0d, got %0d",
                             results_seen, want.density_tenths, density_tenths));
          if (density_updated !== want.density_updated)
            report($sformatf("word %0d density_updated: expected %0d, got %0d",
                             results_seen, want.density_updated, density_updated));
        end
      end
      if (in_valid && in_ready) begin
        sequence_tick(adc_sample, next_word);
        pending_results.push_back(next_word);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_word(input logic [ADC_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_samples(input int n);
    logic [ADC_W-1:0] s;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = '1;
          2: s = ZERO_KNEE;
          default: s = ZERO_KNEE + 1'b1;
        endcase
      end else begin
        s = ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
      end
      send_word(s);
    end
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen < words_sent);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TICK_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SAMPLE_DELAY: lim_delay = v;
      REG_HOLD:         lim_hold = v;
      REG_SLEEP:        lim_sleep = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx, input logic [TICK_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[TICK_W-1:0] !== v)
      report($sformatf("register %0d read: expected %0d, got %0d", idx, v, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_timing(input logic [TICK_W-1:0] d, input logic [TICK_W-1:0] h,
                              input logic [TICK_W-1:0] s);
    write_reg(REG_SAMPLE_DELAY, d);
    write_reg(REG_HOLD, h);
    write_reg(REG_SLEEP, s);
  endtask

  task automatic test_reset_defaults;
    read_reg(REG_SAMPLE_DELAY, DEF_DELAY);
    read_reg(REG_HOLD, DEF_HOLD);
    read_reg(REG_SLEEP, DEF_SLEEP);
    // power-on timing through capture, LED off and into sleep
    send_samples(32'(DEF_DELAY) + 32'(DEF_HOLD) + 60);
    wait_drained;
  endtask

  // zero limits give a four-tick cycle, so four equal words force one capture
  task automatic test_zero_timing_density;
    logic [ADC_W-1:0] corner [6];
    corner = '{12'd0, 12'hFFF, ZERO_KNEE, ZERO_KNEE + 12'd1, 12'hAAA, 12'h555};
    write_timing('0, '0, '0);
    foreach (corner[i]) repeat (4) send_word(corner[i]);
    wait_drained;
  endtask

  task automatic test_register_access;
    write_timing(16'd3, 16'd2, 16'd5);
    write_reg(REG_UNMAPPED, 16'($urandom));
    read_reg(REG_SAMPLE_DELAY, 16'd3);
    read_reg(REG_HOLD, 16'd2);
    read_reg(REG_SLEEP, 16'd5);
    send_samples(40);
    wait_drained;
  endtask

  task automatic test_output_stall;
    hold_left = 80;
    send_samples(120);
    wait_drained;
    send_samples(40);
    wait_drained;
  endtask

  task automatic test_random_phases;
    for (int p = 0; p < 6; p++) begin
      if (p < 2) set_idling(13, 45);
      else if (p < 4) set_idling(45, 13);
      else set_idling(0, 0);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, 16'($urandom));
      write_timing(16'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 40 : 6)),
                   16'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 40 : 6)),
                   16'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 40 : 6)));
      send_samples(200);
      wait_drained;
    end
  endtask

  task automatic test_max_timing;
    set_idling(0, 0);
    write_timing(TICK_MAX, TICK_MAX, TICK_MAX);
    read_reg(REG_SAMPLE_DELAY, TICK_MAX);
    read_reg(REG_HOLD, TICK_MAX);
    read_reg(REG_SLEEP, TICK_MAX);
    send_samples(100);
    wait_drained;
  endtask

  initial begin
    seq_phase = PH_CODE_IDLE;
    seq_ticks = '0;
    held_sample = '0;
    density_now = '0;
    led_lit = 1'b0;
    lim_delay = DEF_DELAY;
    lim_hold = DEF_HOLD;
    lim_sleep = DEF_SLEEP;
    set_idling(13, 45);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults;
    test_zero_timing_density;
    test_register_access;
    test_output_stall;
    test_random_phases;
    test_max_timing;
    repeat (4) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
